// ===== hdl/smx_pkg.sv =====
// Shared types and constants for the stack machine executor.
// Holds opcodes, fault codes, request/response payloads and the front-to-back queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

   // opcodes as they arrive on the request channel
   localparam logic [3:0] OP_IMM  = 4'd0;
   localparam logic [3:0] OP_PUSH = 4'd1;
   localparam logic [3:0] OP_JMP  = 4'd2;
   localparam logic [3:0] OP_JZ   = 4'd3;
   localparam logic [3:0] OP_JNZ  = 4'd4;
   localparam logic [3:0] OP_CALL = 4'd5;
   localparam logic [3:0] OP_ENT  = 4'd6;
   localparam logic [3:0] OP_ADJ  = 4'd7;
   localparam logic [3:0] OP_ADD  = 4'd8;
   localparam logic [3:0] OP_SUB  = 4'd9;
   localparam logic [3:0] OP_MUL  = 4'd10;
   localparam logic [3:0] OP_DIV  = 4'd11;
   localparam logic [3:0] OP_EXIT = 4'd12;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
   localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;
   localparam logic [1:0] FAULT_DIV_ZERO  = 2'd3;

   typedef enum logic [3:0] {
      K_IMM, K_PUSH, K_JMP, K_JZ, K_JNZ, K_CALL,
      K_ADD, K_SUB, K_MUL, K_DIV, K_EXIT, K_NOP
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_DIVIDE, ST_REFILL
   } back_state_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic signed [31:0] acc_value;
      logic signed [31:0] stack_top;
      logic [8:0]         stack_level;
      logic               halted;
      logic signed [31:0] exit_value;
      logic [1:0]         fault;
   } rsp_type;

   typedef struct packed {
      op_kind_type kind;
      logic [31:0] operand;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

`default_nettype wire

// ===== hdl/smx_front.sv =====
// Front end: accepts requests, decodes the opcode into an operation class
// and holds decoded requests in a two-entry queue. Depends on smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smx_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire smx_pkg::req_type        req_data,
   output smx_pkg::queue_head_type      head,
   input  wire logic                    pop
);

   smx_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   smx_pkg::op_kind_type kind;

   always_comb begin
      unique case (req_data.mode) inside
         smx_pkg::OP_IMM:  kind = smx_pkg::K_IMM;
         smx_pkg::OP_PUSH: kind = smx_pkg::K_PUSH;
         smx_pkg::OP_JMP:  kind = smx_pkg::K_JMP;
         smx_pkg::OP_JZ:   kind = smx_pkg::K_JZ;
         smx_pkg::OP_JNZ:  kind = smx_pkg::K_JNZ;
         smx_pkg::OP_CALL: kind = smx_pkg::K_CALL;
         smx_pkg::OP_ADD:  kind = smx_pkg::K_ADD;
         smx_pkg::OP_SUB:  kind = smx_pkg::K_SUB;
         smx_pkg::OP_MUL:  kind = smx_pkg::K_MUL;
         smx_pkg::OP_DIV:  kind = smx_pkg::K_DIV;
         smx_pkg::OP_EXIT: kind = smx_pkg::K_EXIT;
         smx_pkg::OP_ENT, smx_pkg::OP_ADJ: kind = smx_pkg::K_NOP;
         default:          kind = smx_pkg::K_NOP;
      endcase
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   assign head = {(fill_ff != 2'd0), q_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff].kind    <= kind;
         q_ff[wr_ptr_ff].operand <= req_data.operand;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/smx_divider.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating
// toward zero. Standalone; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module smx_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = 32'd0;
         quo_in  = dividend[31] ? -dividend : dividend;
         den_in  = divisor[31] ? -divisor : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         // restoring step: keep the trial difference when it did not borrow
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

`default_nettype wire

// ===== hdl/smx_back.sv =====
// Back end: executes decoded instructions against pc, accumulator and stack,
// and holds the response register. Depends on smx_pkg and smx_divider.
`timescale 1ns / 1ps
`default_nettype none

module smx_back #(
   parameter int STACK_DEPTH = 256,
   parameter int PC_WIDTH    = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire smx_pkg::queue_head_type head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output smx_pkg::rsp_type             rsp_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   smx_pkg::back_state_type state_ff, state_in;

   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   logic [31:0]         acc_ff, acc_in;
   logic [31:0]         top_ff, top_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                halt_ff, halt_in;
   logic [31:0]         exit_ff, exit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   smx_pkg::rsp_type    rsp_ff, rsp_in;

   // stack memory holds the entries below the top; the top lives in top_ff
   logic [31:0]   mem [STACK_DEPTH];
   logic [31:0]   rd_ff;
   logic          mem_we;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_m2;

   logic                out_free;
   logic                go;
   logic                empty;
   logic                full;
   logic                start_alu;
   logic                start_div;
   logic                div_done;
   logic [31:0]         div_quo;
   logic [31:0]         alu_res;
   logic [31:0]         top_or_zero;
   logic [PC_WIDTH-1:0] pc_plus1;
   logic [PC_WIDTH-1:0] pc_plus2;
   logic [PC_WIDTH-1:0] target;
   logic                load_rsp;
   logic [1:0]          fault;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign go          = (state_ff == smx_pkg::ST_IDLE) && head.valid && out_free;
   assign empty       = (count_ff == CW'(0));
   assign full        = (count_ff == CW'(STACK_DEPTH));
   assign count_m1    = count_ff - CW'(1);
   assign count_m2    = count_ff - CW'(2);
   assign top_or_zero = empty ? 32'd0 : top_ff;
   assign pc_plus1    = pc_ff + PC_WIDTH'(1);
   assign pc_plus2    = pc_ff + PC_WIDTH'(2);
   assign target      = head.item.operand[PC_WIDTH-1:0];

   assign start_alu = go && !halt_ff && !empty &&
                      (head.item.kind == smx_pkg::K_ADD ||
                       head.item.kind == smx_pkg::K_SUB ||
                       head.item.kind == smx_pkg::K_MUL);
   assign start_div = go && !halt_ff && !empty && (acc_ff != 32'd0) &&
                      (head.item.kind == smx_pkg::K_DIV);

   always_comb begin
      case (head.item.kind) inside
         smx_pkg::K_ADD: alu_res = top_ff + acc_ff;
         smx_pkg::K_SUB: alu_res = top_ff - acc_ff;
         default:        alu_res = 32'(top_ff * acc_ff);
      endcase
   end

   smx_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .dividend (top_ff),
      .divisor  (acc_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smx_pkg::ST_IDLE: begin
            if (start_alu) begin
               state_in = smx_pkg::ST_REFILL;
            end else if (start_div) begin
               state_in = smx_pkg::ST_DIVIDE;
            end
         end
         smx_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = smx_pkg::ST_REFILL;
            end
         end
         smx_pkg::ST_REFILL: state_in = smx_pkg::ST_IDLE;
         default:            state_in = smx_pkg::ST_IDLE;
      endcase
   end

   // architectural updates and response
   always_comb begin
      pc_in    = pc_ff;
      acc_in   = acc_ff;
      top_in   = top_ff;
      count_in = count_ff;
      halt_in  = halt_ff;
      exit_in  = exit_ff;
      fault    = smx_pkg::FAULT_NONE;
      mem_we   = 1'b0;
      pop      = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         smx_pkg::ST_IDLE: begin
            if (go) begin
               pop      = 1'b1;
               load_rsp = !(start_alu || start_div);
               if (!halt_ff) begin
                  case (head.item.kind) inside
                     smx_pkg::K_IMM: begin
                        acc_in = head.item.operand;
                        pc_in  = pc_plus2;
                     end
                     smx_pkg::K_PUSH: begin
                        if (full) begin
                           fault = smx_pkg::FAULT_OVERFLOW;
                        end else begin
                           mem_we   = !empty;
                           top_in   = acc_ff;
                           count_in = count_ff + CW'(1);
                           pc_in    = pc_plus1;
                        end
                     end
                     smx_pkg::K_JMP: pc_in = target;
                     smx_pkg::K_JZ:  pc_in = (acc_ff != 32'd0) ? pc_plus2 : target;
                     smx_pkg::K_JNZ: pc_in = (acc_ff != 32'd0) ? target : pc_plus2;
                     smx_pkg::K_CALL: begin
                        if (full) begin
                           fault = smx_pkg::FAULT_OVERFLOW;
                        end else begin
                           mem_we   = !empty;
                           top_in   = 32'(pc_plus2);
                           count_in = count_ff + CW'(1);
                           pc_in    = target;
                        end
                     end
                     smx_pkg::K_ADD, smx_pkg::K_SUB, smx_pkg::K_MUL: begin
                        if (empty) begin
                           fault = smx_pkg::FAULT_UNDERFLOW;
                        end else begin
                           acc_in = alu_res;
                           pc_in  = pc_plus1;
                        end
                     end
                     smx_pkg::K_DIV: begin
                        if (empty) begin
                           fault = smx_pkg::FAULT_UNDERFLOW;
                        end else if (acc_ff == 32'd0) begin
                           fault = smx_pkg::FAULT_DIV_ZERO;
                        end
                     end
                     smx_pkg::K_EXIT: begin
                        exit_in = top_or_zero;
                        halt_in = 1'b1;
                        pc_in   = pc_plus1;
                     end
                     default: pc_in = pc_plus1;
                  endcase
               end
            end
         end
         smx_pkg::ST_DIVIDE: begin
            if (div_done) begin
               acc_in = div_quo;
               pc_in  = pc_plus1;
            end
         end
         smx_pkg::ST_REFILL: begin
            // popped: the entry below becomes the top
            top_in   = rd_ff;
            count_in = count_m1;
            load_rsp = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in       = 1'b1;
         rsp_in.next_pc     = 16'(pc_in);
         rsp_in.acc_value   = acc_in;
         rsp_in.stack_top   = (count_in == CW'(0)) ? 32'd0 : top_in;
         rsp_in.stack_level = 9'(count_in);
         rsp_in.halted      = halt_in;
         rsp_in.exit_value  = exit_in;
         rsp_in.fault       = fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smx_pkg::ST_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         count_ff     <= '0;
         halt_ff      <= 1'b0;
         exit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         halt_ff      <= halt_in;
         exit_ff      <= exit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_m1[AW-1:0]] <= top_ff;
      end
      rd_ff <= mem[count_m2[AW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/stack_machine_executor_core.sv =====
// Top level of the stack machine executor: front end, queue and back end.
// Depends on smx_pkg, smx_front and smx_back.
`timescale 1ns / 1ps
`default_nettype none

// Executes one instruction of a small accumulator-plus-stack machine per
// request and returns one response with the state after it. Jumps, loads,
// pushes, calls, exit and no-ops write their response as they leave the
// queue head; ADD, SUB and MUL pass through a refill state because the new
// stack top comes back from the registered read port of the stack memory;
// DIV waits in a divide state for the one-bit-per-cycle divider (32 steps
// plus start, finish and refill). A two-entry queue sits between the
// decoding front end and the execution back end; while a response waits
// in the response register and the receiver stalls, the back end holds,
// and the queue keeps taking requests until it is full. Stack overflow,
// underflow and divide by zero report a fault and leave all state
// untouched. After exit, requests are answered with the frozen state. The
// stack store needs no clearing after reset; the top of stack is held in a
// register and entries below it live in a STACK_DEPTH-word memory.
module stack_machine_executor_core #(
   parameter int STACK_DEPTH = 256,
   parameter int PC_WIDTH    = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire smx_pkg::req_type req_data,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smx_pkg::rsp_type      rsp_data
);

   // decoded request at the queue head, and its consume strobe
   smx_pkg::queue_head_type head;
   logic                    pop;

   smx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   // execution: pc, accumulator, stack, halt and the response register
   smx_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .PC_WIDTH    (PC_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for stack_machine_executor_core: directed table, then random programs.
// Responses are checked field by field against the machine model or a typed row.
// Depends on smx_pkg and the RTL of stack_machine_executor_core.
`timescale 1ns / 1ps

module tb;

   // Opcodes the block treats as no-ops, beyond ENT and ADJ
   localparam logic [3:0] OP_SPARE_LO = 4'd13;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   localparam int STACK_WORDS  = 256;
   localparam int ITEM_TARGET  = 1550;
   // DIV is the slowest op; leave room after the last response
   localparam int DRAIN_CYCLES = 60;
   // Worst case is far below this: every request a DIV, max sender gap and
   // max receiver stall each time, plus the one long hold
   localparam int CYCLE_LIMIT  = 1000000;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   smx_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   smx_pkg::rsp_type rsp_data;

   stack_machine_executor_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Machine model: its own copy of the architectural state
   // ------------------------------------------------------------------
   logic [15:0] mach_pc     = '0;
   logic [31:0] mach_acc    = '0;
   logic [31:0] mach_stack [STACK_WORDS];
   int          mach_depth  = 0;
   logic        mach_halted = 1'b0;
   logic [31:0] mach_exit   = '0;

   // Expected responses, oldest first
   smx_pkg::rsp_type pending_states [$];

   int  mismatch_count = 0;
   int  responses_seen = 0;
   int  requests_sent  = 0;
   int  cycle_count    = 0;
   // Phase with no sender gaps and no random receiver stalls
   bit  quiet_phase    = 1'b0;

   logic [3:0] alu_ops [4] = '{smx_pkg::OP_ADD, smx_pkg::OP_SUB,
                               smx_pkg::OP_MUL, smx_pkg::OP_DIV};

   // Apply one instruction to the model and return the response it produces.
   // Faults leave every piece of state alone, PC included.
   task automatic execute_instruction(input smx_pkg::req_type r,
                                      output smx_pkg::rsp_type res);
      logic [1:0]  flt;
      logic [15:0] pc_n;
      logic [31:0] arg;
      logic [31:0] left;
      flt  = smx_pkg::FAULT_NONE;
      arg  = r.operand;
      pc_n = mach_pc;
      if (!mach_halted) begin
         case (r.mode)
            smx_pkg::OP_IMM: begin
               mach_acc = arg;
               pc_n     = mach_pc + 16'd2;
            end
            smx_pkg::OP_PUSH: begin
               if (mach_depth >= STACK_WORDS) begin
                  flt = smx_pkg::FAULT_OVERFLOW;
               end else begin
                  mach_stack[mach_depth] = mach_acc;
                  mach_depth++;
                  pc_n = mach_pc + 16'd1;
               end
            end
            smx_pkg::OP_JMP: pc_n = arg[15:0];
            smx_pkg::OP_JZ:  pc_n = (mach_acc != 0) ? mach_pc + 16'd2 : arg[15:0];
            smx_pkg::OP_JNZ: pc_n = (mach_acc != 0) ? arg[15:0] : mach_pc + 16'd2;
            smx_pkg::OP_CALL: begin
               if (mach_depth >= STACK_WORDS) begin
                  flt = smx_pkg::FAULT_OVERFLOW;
               end else begin
                  // return address wraps at the PC width, then zero-extends
                  mach_stack[mach_depth] = {16'd0, mach_pc + 16'd2};
                  mach_depth++;
                  pc_n = arg[15:0];
               end
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
               if (mach_depth == 0) begin
                  flt = smx_pkg::FAULT_UNDERFLOW;
               end else if (r.mode == smx_pkg::OP_DIV && mach_acc == 0) begin
                  flt = smx_pkg::FAULT_DIV_ZERO;
               end else begin
                  left = mach_stack[mach_depth - 1];
                  case (r.mode)
                     smx_pkg::OP_ADD: mach_acc = left + mach_acc;
                     smx_pkg::OP_SUB: mach_acc = left - mach_acc;
                     smx_pkg::OP_MUL: mach_acc = left * mach_acc;
                     default: begin
                        // most negative / -1 wraps back to most negative
                        if (left == 32'h8000_0000 && mach_acc == 32'hFFFF_FFFF)
                           mach_acc = 32'h8000_0000;
                        else
                           mach_acc = $signed(left) / $signed(mach_acc);
                     end
                  endcase
                  mach_depth--;
                  pc_n = mach_pc + 16'd1;
               end
            end
            smx_pkg::OP_EXIT: begin
               mach_exit   = (mach_depth != 0) ? mach_stack[mach_depth - 1] : '0;
               mach_halted = 1'b1;
               pc_n        = mach_pc + 16'd1;
            end
            default: pc_n = mach_pc + 16'd1;
         endcase
         if (flt == smx_pkg::FAULT_NONE)
            mach_pc = pc_n;
      end
      res.next_pc     = mach_pc;
      res.acc_value   = mach_acc;
      res.stack_top   = (mach_depth != 0) ? mach_stack[mach_depth - 1] : '0;
      res.stack_level = mach_depth[8:0];
      res.halted      = mach_halted;
      res.exit_value  = mach_exit;
      res.fault       = (mach_halted && r.mode != smx_pkg::OP_EXIT) ?
                        smx_pkg::FAULT_NONE : flt;
   endtask

   // One line per mismatch
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: response %0d %s got %h want %h", responses_seen, field, got, want);
      mismatch_count++;
   endtask

   // Offer one request, hold it until accepted, then queue what it should produce.
   // A typed expectation, when given, replaces the model's own result.
   task automatic send_request(input smx_pkg::req_type r, input bit use_typed,
                               input smx_pkg::rsp_type typed_want);
      int               gap;
      smx_pkg::rsp_type predicted;
      if (quiet_phase) begin
         gap = 0;
      end else begin
         gap = $urandom_range(0, 99);
         if (gap < 55)
            gap = 0;
         else if (gap < 90)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      // values read here are the ones present at the edge
      do @(posedge clock); while (req_stall !== 1'b0);
      execute_instruction(r, predicted);
      pending_states.push_back(use_typed ? typed_want : predicted);
      requests_sent++;
      quiet_phase = ((requests_sent / 150) % 3) == 2;
   endtask

   task automatic issue(input logic [3:0] mode, input logic [31:0] operand);
      smx_pkg::req_type r;
      r.mode    = mode;
      r.operand = operand;
      send_request(r, 1'b0, '0);
   endtask

   // Operand values that hit the arithmetic corners often
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return 32'h7FFF_FFFF;
         5:       return $urandom_range(0, 32) - 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic smx_pkg::rsp_type frame(input logic [15:0] pc,
                                              input logic [31:0] acc,
                                              input logic [31:0] top,
                                              input logic [8:0] lvl,
                                              input logic [1:0] flt);
      smx_pkg::rsp_type f;
      f.next_pc     = pc;
      f.acc_value   = acc;
      f.stack_top   = top;
      f.stack_level = lvl;
      f.halted      = 1'b0;
      f.exit_value  = '0;
      f.fault       = flt;
      return f;
   endfunction

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   typedef struct {
      logic [3:0]       mode;
      logic [31:0]      operand;
      bit               typed;
      smx_pkg::rsp_type want;
   } step_row_type;

   step_row_type directed_rows [$];

   function automatic void add_row(input logic [3:0] mode, input logic [31:0] operand,
                                   input bit typed, input smx_pkg::rsp_type want);
      step_row_type row;
      row.mode    = mode;
      row.operand = operand;
      row.typed   = typed;
      row.want    = want;
      directed_rows.push_back(row);
   endfunction

   // ------------------------------------------------------------------
   // Response checker: every accepted response against the oldest expectation
   // ------------------------------------------------------------------
   initial begin : rsp_checker
      smx_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_states.size() == 0) begin
               report_mismatch("with nothing pending, next_pc",
                               32'(rsp_data.next_pc), '0);
            end else begin
               want = pending_states.pop_front();
               if (rsp_data.next_pc !== want.next_pc)
                  report_mismatch("next_pc", 32'(rsp_data.next_pc), 32'(want.next_pc));
               if (rsp_data.acc_value !== want.acc_value)
                  report_mismatch("acc_value", rsp_data.acc_value, want.acc_value);
               if (rsp_data.stack_top !== want.stack_top)
                  report_mismatch("stack_top", rsp_data.stack_top, want.stack_top);
               if (rsp_data.stack_level !== want.stack_level)
                  report_mismatch("stack_level", 32'(rsp_data.stack_level),
                                  32'(want.stack_level));
               if (rsp_data.halted !== want.halted)
                  report_mismatch("halted", 32'(rsp_data.halted), 32'(want.halted));
               if (rsp_data.exit_value !== want.exit_value)
                  report_mismatch("exit_value", rsp_data.exit_value, want.exit_value);
               if (rsp_data.fault !== want.fault)
                  report_mismatch("fault", 32'(rsp_data.fault), 32'(want.fault));
            end
            responses_seen++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver stalls: random runs, quiet phases, and one long hold-off that
   // backs the block up until it stalls the request side
   // ------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int run_left;
      int hold_left;
      bit hold_done;
      run_left  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && responses_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = 250;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else if (quiet_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 9) < 3);
            run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
         end
      end
   end

   // Cycle budget; ends the run as a failure if the block hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      smx_pkg::req_type r;
      int               fills_done;
      int               n;
      logic [3:0]       m;
      fills_done = 0;

      // Empty stack: pops underflow, and underflow wins over divide by zero
      add_row(smx_pkg::OP_ADD,  32'h0,         1'b1,
              frame(16'd0, 32'h0, 32'h0, 9'd0, smx_pkg::FAULT_UNDERFLOW));
      add_row(smx_pkg::OP_DIV,  32'h0,         1'b1,
              frame(16'd0, 32'h0, 32'h0, 9'd0, smx_pkg::FAULT_UNDERFLOW));
      // Most negative / -1 wraps
      add_row(smx_pkg::OP_IMM,  32'h8000_0000, 1'b1,
              frame(16'd2, 32'h8000_0000, 32'h0, 9'd0, smx_pkg::FAULT_NONE));
      add_row(smx_pkg::OP_PUSH, 32'h1234_5678, 1'b1,
              frame(16'd3, 32'h8000_0000, 32'h8000_0000, 9'd1, smx_pkg::FAULT_NONE));
      add_row(smx_pkg::OP_IMM,  32'hFFFF_FFFF, 1'b1,
              frame(16'd5, 32'hFFFF_FFFF, 32'h8000_0000, 9'd1, smx_pkg::FAULT_NONE));
      add_row(smx_pkg::OP_DIV,  32'h0,         1'b1,
              frame(16'd6, 32'h8000_0000, 32'h0, 9'd0, smx_pkg::FAULT_NONE));
      // Divide by zero leaves everything in place
      add_row(smx_pkg::OP_PUSH, 32'h0,         1'b1,
              frame(16'd7, 32'h8000_0000, 32'h8000_0000, 9'd1, smx_pkg::FAULT_NONE));
      add_row(smx_pkg::OP_IMM,  32'h0,         1'b1,
              frame(16'd9, 32'h0, 32'h8000_0000, 9'd1, smx_pkg::FAULT_NONE));
      add_row(smx_pkg::OP_DIV,  32'hFFFF_FFFF, 1'b1,
              frame(16'd9, 32'h0, 32'h8000_0000, 9'd1, smx_pkg::FAULT_DIV_ZERO));
      // Add, branches both ways, call with PC wrap, no-ops
      add_row(smx_pkg::OP_IMM,  32'h7FFF_FFFF, 1'b0, '0);
      add_row(smx_pkg::OP_ADD,  32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_JZ,   32'hFFFF_1234, 1'b0, '0);
      add_row(smx_pkg::OP_JNZ,  32'hABCD_FFFF, 1'b0, '0);
      add_row(smx_pkg::OP_CALL, 32'h0000_0010, 1'b0, '0);
      add_row(smx_pkg::OP_ENT,  32'h5555_AAAA, 1'b0, '0);
      add_row(smx_pkg::OP_ADJ,  32'hAAAA_5555, 1'b0, '0);
      add_row(OP_SPARE_LO,      32'hFFFF_FFFF, 1'b0, '0);
      add_row(OP_SPARE_HI,      32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_MUL,  32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_JMP,  32'hFFFF_FFFE, 1'b0, '0);
      add_row(smx_pkg::OP_IMM,  32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_JZ,   32'h0000_FFFF, 1'b0, '0);
      add_row(smx_pkg::OP_JNZ,  32'h0000_0055, 1'b0, '0);
      // Subtract order, then division truncating toward zero
      add_row(smx_pkg::OP_PUSH, 32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_IMM,  32'h5,         1'b0, '0);
      add_row(smx_pkg::OP_SUB,  32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_PUSH, 32'h0,         1'b0, '0);
      add_row(smx_pkg::OP_IMM,  32'h2,         1'b0, '0);
      add_row(smx_pkg::OP_DIV,  32'h0,         1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r.mode    = directed_rows[i].mode;
         r.operand = directed_rows[i].operand;
         send_request(r, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random programs. EXIT halts the block for good and reset is never
      // repeated, so it is held back until the very end.
      while (requests_sent < ITEM_TARGET) begin
         if ((fills_done == 0 && requests_sent >= 500) ||
             (fills_done == 1 && requests_sent >= 1100)) begin
            // fill the stack, then push and call into a full stack
            while (mach_depth < STACK_WORDS) begin
               if ($urandom_range(0, 3) == 0)
                  issue(smx_pkg::OP_IMM, pick_word());
               issue(smx_pkg::OP_PUSH, $urandom);
            end
            issue(smx_pkg::OP_PUSH, $urandom);
            issue(smx_pkg::OP_CALL, $urandom);
            fills_done++;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // top-of-stack op acc with corner operands
               issue(smx_pkg::OP_IMM, pick_word());
               if (mach_depth < STACK_WORDS - 2 && $urandom_range(0, 9) != 0)
                  issue(smx_pkg::OP_PUSH, $urandom);
               if ($urandom_range(0, 4) != 0)
                  issue(smx_pkg::OP_IMM, pick_word());
               issue(alu_ops[2'($urandom_range(0, 3))], $urandom);
               // drain a deep stack back down over time
               if (mach_depth > 48)
                  issue(alu_ops[2'($urandom_range(0, 3))], $urandom);
            end
            5, 6: begin
               if ($urandom_range(0, 1) != 0)
                  issue(smx_pkg::OP_IMM, $urandom_range(0, 1) ? 32'h0 : pick_word());
               case ($urandom_range(0, 3))
                  0:       issue(smx_pkg::OP_JMP, $urandom);
                  1:       issue(smx_pkg::OP_JZ, $urandom);
                  2:       issue(smx_pkg::OP_JNZ, $urandom);
                  default: issue(smx_pkg::OP_CALL, $urandom);
               endcase
            end
            7: begin
               // divide, zero divisor about one time in ten
               issue(smx_pkg::OP_IMM, pick_word());
               issue(smx_pkg::OP_DIV, $urandom);
            end
            default: begin
               // noise: any opcode but EXIT, any operand
               n = $urandom_range(1, 4);
               repeat (n) begin
                  m = 4'($urandom_range(0, 15));
                  if (m == smx_pkg::OP_EXIT)
                     m = smx_pkg::OP_ENT;
                  issue(m, $urandom);
               end
            end
         endcase
      end

      // Halt, then show that later requests see the frozen state
      issue(smx_pkg::OP_EXIT, $urandom);
      repeat (6)
         issue(4'($urandom_range(0, 15)), $urandom);

      req_valid <= 1'b0;
      while (pending_states.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
